// File: hw/rtl/isort_pkg.sv
// Shared types for the insertion sorter: value type and cell control word.
package isort_pkg;

	localparam int VALUE_W = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

	// Control word broadcast from the top level to every cell.
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

endpackage

// File: hw/rtl/isort_cell.sv
// One cell of the sorting chain: holds one value, and shifts, inserts or keeps it as the control word says.
module isort_cell
	import isort_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  value_t    new_value,
	input  logic      occupied,
	input  logic      left_greater,
	input  value_t    left_value,
	input  value_t    right_value,
	output value_t    value,
	output logic      greater
);

	value_t value_q;

	// An empty cell counts as greater, so the new word lands after the last held one.
	assign greater = !occupied || (value_q > new_value);
	assign value   = value_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= right_value;
		end else if (ctl.insert && greater) begin
			value_q <= left_greater ? left_value : new_value;
		end
	end

endmodule

// File: hw/rtl/insertion_sort_ascending.sv
// Top level of the insertion sorter: cell chain, drain control and output register.
//
// Input channel (item_valid / item_stall, value_in, last_item): one word per
// cycle is taken while the block is filling. Each word is inserted into the
// chain of CAPACITY cells by a broadcast compare; equal values keep their
// arrival order. Once CAPACITY words are held, further words of the set are
// dropped and the set is marked as overflowed.
// A word with last_item set closes the set. The block then drains: item_stall
// stays high while the held words leave cell 0 one per cycle unless the result
// side stalls, in ascending order, through the result register (result_valid /
// result_stall, sorted_value, last_of_run, overflow). The closing word sets the
// drain state, from which the first result is loaded into the result register.
// The drain rate is set by the single output register, so a stall on the
// result side holds the chain and the register unchanged.
// Input is taken again in the cycle after the last result is loaded.
// Reset clears the count, the overflow mark, the drain state and result_valid;
// cell contents are not reset and are only read below the count.
module insertion_sort_ascending
	import isort_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	output logic   item_stall,
	input  value_t value_in,
	input  logic   last_item,
	output logic   result_valid,
	input  logic   result_stall,
	output value_t sorted_value,
	output logic   last_of_run,
	output logic   overflow
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic          draining_q;
	logic          out_valid_q;
	value_t        out_value_q;
	logic          out_last_q;
	logic          out_ovf_q;

	value_t        cell_value [CAPACITY];
	logic          cell_greater [CAPACITY];
	cell_ctl_t     ctl;
	logic          accept;
	logic          has_room;
	logic          load;

	// Cell 0 has no left neighbour; its left value is never selected.
	function automatic value_t new_dummy();
		return '0;
	endfunction

	assign item_stall = draining_q;
	assign accept     = item_valid && !draining_q;
	assign has_room   = count_q < CW'(CAPACITY);
	assign load       = draining_q && (!out_valid_q || !result_stall);

	assign ctl.insert = accept && has_room;
	assign ctl.shift  = load;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   occ;
		logic   lg;
		value_t lv;
		value_t rv;

		assign occ = CW'(i) < count_q;
		if (i == 0) begin : g_first
			assign lg = 1'b0;
			assign lv = new_dummy();
		end else begin : g_mid
			assign lg = cell_greater[i-1];
			assign lv = cell_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv = cell_value[i];
		end else begin : g_inner
			assign rv = cell_value[i+1];
		end

		isort_cell u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.new_value    (value_in),
			.occupied     (occ),
			.left_greater (lg),
			.left_value   (lv),
			.right_value  (rv),
			.value        (cell_value[i]),
			.greater      (cell_greater[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dropped_q   <= 1'b0;
			draining_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (has_room) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
				if (last_item) begin
					draining_q <= 1'b1;
				end
			end else if (load) begin
				count_q <= count_q - CW'(1);
				if (count_q == CW'(1)) begin
					draining_q <= 1'b0;
					dropped_q  <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q <= cell_value[0];
			out_last_q  <= count_q == CW'(1);
			out_ovf_q   <= dropped_q;
		end
	end

	assign result_valid = out_valid_q;
	assign sorted_value = out_value_q;
	assign last_of_run  = out_last_q;
	assign overflow     = out_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("held count exceeds capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> count_q != '0)
		else $error("draining with no held words");

	a_final_word: assert property (@(posedge clk) disable iff (!arst_n)
		load && count_q == CW'(1) |=> !draining_q && result_valid && last_of_run)
		else $error("final word of the set not marked or drain not ended");

	a_mark_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && count_q != CW'(1) |=> draining_q && !last_of_run)
		else $error("last-of-run mark on an inner word");

endmodule
